### rtl/core/gaussian_window_filter_macros.svh
// Assertion macros for the Gaussian window filter.
// Included by the top level; no other dependencies.
`ifndef GAUSSIAN_WINDOW_FILTER_MACROS_SVH
`define GAUSSIAN_WINDOW_FILTER_MACROS_SVH
`ifndef SYNTHESIS
`define GWF_ASSERT_IMP(lbl, ant, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error("gwf assertion failed");
`define GWF_ASSERT_NXT(lbl, ant, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error("gwf assertion failed");
`else
`define GWF_ASSERT_IMP(lbl, ant, cons)
`define GWF_ASSERT_NXT(lbl, ant, cons)
`endif
`endif

### rtl/core/gwf_pkg.sv
// Shared constants and types of the Gaussian window filter.
// No dependencies.
package gwf_pkg;

    localparam int RADIUS    = 3;
    localparam int SIDE      = 2 * RADIUS + 1;
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WID_W     = $clog2(MAX_WIDTH + 1);
    localparam int IMGW_W    = 11;
    localparam int ROW_W     = 13;
    localparam int RING_ROWS = 16;
    localparam int SLOT_W    = $clog2(RING_ROWS);
    localparam int ADDR_W    = SLOT_W + COL_W;
    localparam int SMP_W     = 16;
    localparam int PIX_W     = 3 * SMP_W;
    localparam int WREG_W    = 64;
    localparam int WGT_W     = 16;
    localparam int TAP_W     = $clog2(SIDE);
    localparam int DIST_W    = (RADIUS > 1) ? $clog2(RADIUS + 1) : 1;
    localparam int DLY_W     = WID_W + 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_VWEIGHTS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HWEIGHTS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR    = 3'd5;

    localparam logic [1:0] BND_ZERO   = 2'd0;
    localparam logic [1:0] BND_MIRROR = 2'd1;
    localparam logic [1:0] BND_ADJUST = 2'd2;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    localparam int JOBQ_DEPTH = 2;
    localparam int JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } t_job;

    typedef struct packed {
        logic [WREG_W-1:0] vweights;
        logic [WREG_W-1:0] hweights;
        logic [1:0]        bmode;
        logic [WID_W-1:0]  width;
        logic [ROW_W-1:0]  height;
        logic              color;
    } t_cfg;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  data;
    } t_mem_wr;

    typedef struct packed {
        logic idle;
        logic out_valid;
    } t_back_stat;

endpackage

### rtl/core/gaussian_window_filter.sv
// Top level of the Gaussian window filter: front, job queue and back.
// Depends on gwf_pkg, gwf_front, gwf_jobq, gwf_back and the macro header.
//
// Streaming (2R+1)-square Gaussian filter over raster-order pixels with up
// to three Q3.12 channels. For each output pixel the back end walks the 49
// taps one per cycle through the single read port of the line store, then a
// four-stage multiply-accumulate pipe drains, and in kernel-adjust mode a
// one-bit-per-cycle divider runs 17 steps. Input items are taken in one cycle
// each while the two-entry job queue has room; while it is full every input
// item waits, warm-up pixels and spare drains too. After the frame's last
// pixel, send one drain item per remaining output.
// Register writes are accepted every cycle and must be made while idle.
`include "gaussian_window_filter_macros.svh"
module gaussian_window_filter import gwf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 i_req_type,
    input  logic [SMP_W-1:0]     i_in_chan0,
    input  logic [SMP_W-1:0]     i_in_chan1,
    input  logic [SMP_W-1:0]     i_in_chan2,
    output logic                 empty,
    input  logic                 pop,
    output logic [SMP_W-1:0]     o_out_chan0,
    output logic [SMP_W-1:0]     o_out_chan1,
    output logic [SMP_W-1:0]     o_out_chan2,
    output logic                 o_end_of_frame,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WREG_W-1:0]    i_cfg_data
);

    t_cfg                  cfg;
    t_mem_wr               wr;
    t_job                  job_in, job_head;
    t_back_stat            stat;
    logic                  job_push, q_pop, q_empty, q_full, accept, cfg_wr;
    logic [JOBQ_CNT_W-1:0] q_count;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign full        = q_full;
    assign accept      = push && !q_full;
    assign empty       = !stat.out_valid;

    gwf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (cfg_wr),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .i_accept    (accept),
        .i_req_type  (i_req_type),
        .i_chan0     (i_in_chan0),
        .i_chan1     (i_in_chan1),
        .i_chan2     (i_in_chan2),
        .o_wr        (wr),
        .o_job_push  (job_push),
        .o_job       (job_in)
    );

    gwf_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (q_pop),
        .o_head  (job_head),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_count (q_count)
    );

    gwf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_wr      (wr),
        .i_q_empty (q_empty),
        .i_job     (job_head),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_stat    (stat),
        .o_chan0   (o_out_chan0),
        .o_chan1   (o_out_chan1),
        .o_chan2   (o_out_chan2),
        .o_eof     (o_end_of_frame)
    );

    `GWF_ASSERT_IMP(a_q_bound, 1'b1, q_count <= JOBQ_CNT_W'(JOBQ_DEPTH))
    `GWF_ASSERT_NXT(a_pop_starts, q_pop, !stat.idle)
    `GWF_ASSERT_IMP(a_gray_zero, !empty && !cfg.color, o_out_chan1 == '0 && o_out_chan2 == '0)
    `GWF_ASSERT_IMP(a_push_room, job_push, !q_full)

endmodule

### rtl/core/gwf_front.sv
// Front part: configuration registers, input counters, line store writes
// and job issue. Depends on gwf_pkg.
module gwf_front import gwf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WREG_W-1:0]    i_cfg_data,
    output t_cfg                 o_cfg,
    input  logic                 i_accept,
    input  logic                 i_req_type,
    input  logic [SMP_W-1:0]     i_chan0,
    input  logic [SMP_W-1:0]     i_chan1,
    input  logic [SMP_W-1:0]     i_chan2,
    output t_mem_wr              o_wr,
    output logic                 o_job_push,
    output t_job                 o_job
);

    logic [WREG_W-1:0] r_vw, r_hw;
    logic [1:0]        r_bmode;
    logic [IMGW_W-1:0] r_iw;
    logic [ROW_W-1:0]  r_ih;
    logic              r_color;

    logic [ROW_W-1:0]  r_in_row, n_in_row, r_out_row, n_out_row;
    logic [COL_W-1:0]  r_in_col, n_in_col, r_out_col, n_out_col;
    logic [SLOT_W-1:0] r_in_slot, n_in_slot, r_out_slot, n_out_slot;
    logic [DLY_W-1:0]  r_diff, n_diff;

    logic [WID_W-1:0]  w;
    logic [ROW_W-1:0]  h;
    logic [DLY_W-1:0]  dly, diff_inc;
    logic              in_done, out_done, is_pix, wr_en, issue, last;

    always_comb begin
        if (r_iw < IMGW_W'(RADIUS + 1)) begin
            w = WID_W'(RADIUS + 1);
        end else if (32'(r_iw) > 32'(MAX_WIDTH)) begin
            w = WID_W'(MAX_WIDTH);
        end else begin
            w = WID_W'(r_iw);
        end
        h = (r_ih < ROW_W'(RADIUS + 1)) ? ROW_W'(RADIUS + 1) : r_ih;
    end

    assign dly      = DLY_W'(RADIUS) * DLY_W'(w) + DLY_W'(RADIUS);
    assign in_done  = r_in_row >= h;
    assign out_done = r_out_row >= h;
    assign is_pix   = i_req_type == REQ_PIXEL;
    assign diff_inc = r_diff + DLY_W'(1);
    assign wr_en    = i_accept && is_pix && !in_done;
    assign issue    = i_accept && !out_done &&
                      (is_pix ? (!in_done && diff_inc > dly) : in_done);
    assign last     = (r_out_row == h - ROW_W'(1)) && (WID_W'(r_out_col) == w - WID_W'(1));

    always_comb begin
        n_in_row   = r_in_row;
        n_in_col   = r_in_col;
        n_in_slot  = r_in_slot;
        n_out_row  = r_out_row;
        n_out_col  = r_out_col;
        n_out_slot = r_out_slot;
        n_diff     = r_diff;
        if (wr_en) begin
            n_diff = diff_inc;
            if (WID_W'(r_in_col) == w - WID_W'(1)) begin
                n_in_col  = '0;
                n_in_row  = r_in_row + ROW_W'(1);
                n_in_slot = r_in_slot + SLOT_W'(1);
            end else begin
                n_in_col = r_in_col + COL_W'(1);
            end
        end
        if (issue) begin
            n_diff = n_diff - DLY_W'(1);
            if (WID_W'(r_out_col) == w - WID_W'(1)) begin
                n_out_col  = '0;
                n_out_row  = r_out_row + ROW_W'(1);
                n_out_slot = r_out_slot + SLOT_W'(1);
            end else begin
                n_out_col = r_out_col + COL_W'(1);
            end
            if (last) begin
                n_in_row  = '0;
                n_in_col  = '0;
                n_out_row = '0;
                n_out_col = '0;
                n_diff    = '0;
            end
        end
        if (i_cfg_wr && (i_cfg_index == CFG_WIDTH || i_cfg_index == CFG_HEIGHT)) begin
            n_in_row   = '0;
            n_in_col   = '0;
            n_out_row  = '0;
            n_out_col  = '0;
            n_diff     = '0;
            n_out_slot = r_in_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vw       <= '0;
            r_hw       <= '0;
            r_bmode    <= BND_ADJUST;
            r_iw       <= IMGW_W'(512);
            r_ih       <= ROW_W'(512);
            r_color    <= 1'b1;
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_in_slot  <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_out_slot <= '0;
            r_diff     <= '0;
        end else begin
            r_in_row   <= n_in_row;
            r_in_col   <= n_in_col;
            r_in_slot  <= n_in_slot;
            r_out_row  <= n_out_row;
            r_out_col  <= n_out_col;
            r_out_slot <= n_out_slot;
            r_diff     <= n_diff;
            if (i_cfg_wr) begin
                case (i_cfg_index)
                    CFG_VWEIGHTS: r_vw    <= i_cfg_data;
                    CFG_HWEIGHTS: r_hw    <= i_cfg_data;
                    CFG_BOUNDARY: r_bmode <= i_cfg_data[1:0];
                    CFG_WIDTH:    r_iw    <= i_cfg_data[IMGW_W-1:0];
                    CFG_HEIGHT:   r_ih    <= i_cfg_data[ROW_W-1:0];
                    CFG_COLOR:    r_color <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    assign o_cfg.vweights = r_vw;
    assign o_cfg.hweights = r_hw;
    assign o_cfg.bmode    = r_bmode;
    assign o_cfg.width    = w;
    assign o_cfg.height   = h;
    assign o_cfg.color    = r_color;

    assign o_wr.en   = wr_en;
    assign o_wr.addr = {r_in_slot, r_in_col};
    assign o_wr.data = {i_chan2, i_chan1, i_chan0};

    assign o_job_push = issue;
    assign o_job.row  = r_out_row;
    assign o_job.col  = r_out_col;
    assign o_job.slot = r_out_slot;
    assign o_job.last = last;

endmodule

### rtl/core/gwf_jobq.sv
// Two-entry job queue between front and back.
// Depends on gwf_pkg.
module gwf_jobq import gwf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  t_job                  i_job,
    input  logic                  i_pop,
    output t_job                  o_head,
    output logic                  o_empty,
    output logic                  o_full,
    output logic [JOBQ_CNT_W-1:0] o_count
);

    localparam int PTR_W = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;

    t_job                  r_mem [JOBQ_DEPTH];
    logic [PTR_W-1:0]      r_wp, r_rp;
    logic [JOBQ_CNT_W-1:0] r_cnt;
    logic                  do_push, do_pop;

    assign o_empty = r_cnt == '0;
    assign o_full  = r_cnt == JOBQ_CNT_W'(JOBQ_DEPTH);
    assign o_count = r_cnt;
    assign o_head  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (32'(r_wp) == JOBQ_DEPTH - 1) ? '0 : r_wp + PTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= (32'(r_rp) == JOBQ_DEPTH - 1) ? '0 : r_rp + PTR_W'(1);
            end
            r_cnt <= r_cnt + JOBQ_CNT_W'(do_push) - JOBQ_CNT_W'(do_pop);
        end
    end

endmodule

### rtl/core/gwf_back.sv
// Back part: line store, tap sequencer, multiply-accumulate pipeline,
// serial divider for kernel adjust, result register. Depends on gwf_pkg.
module gwf_back import gwf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  t_mem_wr          i_wr,
    input  logic             i_q_empty,
    input  t_job             i_job,
    output logic             o_q_pop,
    input  logic             i_pop,
    output t_back_stat       o_stat,
    output logic [SMP_W-1:0] o_chan0,
    output logic [SMP_W-1:0] o_chan1,
    output logic [SMP_W-1:0] o_chan2,
    output logic             o_eof
);

    localparam int WT_W   = 2 * WGT_W;
    localparam int PROD_W = WT_W + SMP_W;
    localparam int ACC_W  = PROD_W + $clog2(SIDE * SIDE);
    localparam int WSUM_W = WT_W + $clog2(SIDE * SIDE);
    localparam int QBITS  = SMP_W + 1;
    localparam int DIV_W  = WSUM_W + QBITS + 2;
    localparam int QSAT_W = ACC_W - 29;
    localparam int K_W    = $clog2(QBITS);
    localparam int RW     = ROW_W + 2;
    localparam int CW     = COL_W + 3;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_TAPS = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    function automatic logic [SMP_W-1:0] sat16(input logic neg, input logic [QSAT_W-1:0] q);
        logic [SMP_W-1:0] v;
        if (neg) begin
            v = (q > QSAT_W'(32768)) ? 16'h8000 : SMP_W'(~q + QSAT_W'(1));
        end else begin
            v = (q > QSAT_W'(32767)) ? 16'h7fff : SMP_W'(q);
        end
        return v;
    endfunction

    logic [PIX_W-1:0] r_mem [RING_ROWS * MAX_WIDTH];

    t_state             r_state;
    t_job               r_job;
    logic [TAP_W-1:0]   r_ta, r_tb;
    logic               r_issue;
    logic               r_p1_v, r_p1_in, r_p2_v, r_p2_in, r_p3_v, r_p3_in;
    logic [DIST_W-1:0]  r_p1_vi, r_p1_hi;
    logic [PIX_W-1:0]   r_rd;
    logic [WT_W-1:0]    r_wt, r_wt3;
    logic signed [SMP_W-1:0]  r_smp  [3];
    logic signed [PROD_W-1:0] r_prod [3];
    logic signed [ACC_W-1:0]  r_acc  [3];
    logic [WSUM_W-1:0]  r_wsum;
    logic [DIV_W-1:0]   r_rem [3];
    logic [DIV_W-1:0]   r_dsh;
    logic [QBITS-1:0]   r_q [3];
    logic               r_neg [3];
    logic               r_zero;
    logic [K_W-1:0]     r_k;
    logic [SMP_W-1:0]   r_fin [3];
    logic               r_out_v, r_eof;
    logic [SMP_W-1:0]   r_oc [3];

    logic signed [TAP_W:0] a_s, b_s;
    logic signed [RW-1:0]  rr, hs;
    logic signed [CW-1:0]  cc, ws;
    logic                  tap_ok;
    logic [SLOT_W-1:0]     slot;
    logic [DIST_W-1:0]     vi, hi;
    logic [WT_W-1:0]       wmul;
    logic signed [PROD_W:0] pmul [3];
    logic                  pipe_idle, adjust, load_out;
    logic [WSUM_W-1:0]     den;
    logic [ACC_W-1:0]      mag [3];
    logic [ACC_W:0]        rnd [3];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_comb begin
        a_s = $signed({1'b0, r_ta}) - (TAP_W + 1)'(RADIUS);
        b_s = $signed({1'b0, r_tb}) - (TAP_W + 1)'(RADIUS);
        hs  = $signed({2'b0, i_cfg.height});
        ws  = $signed(CW'(i_cfg.width));
        rr  = $signed({2'b0, r_job.row}) + RW'(a_s);
        cc  = $signed(CW'(r_job.col)) + CW'(b_s);
        if (i_cfg.bmode == BND_MIRROR) begin
            if (rr > hs - RW'(1)) begin
                rr = $signed({2'b0, r_job.row}) - RW'(a_s);
            end else if (rr < 0) begin
                rr = -rr;
            end
            if (cc > ws - CW'(1)) begin
                cc = $signed(CW'(r_job.col)) - CW'(b_s);
            end else if (cc < 0) begin
                cc = -cc;
            end
        end
        tap_ok = (rr >= 0) && (rr < hs) && (cc >= 0) && (cc < ws);
        slot   = r_job.slot + rr[SLOT_W-1:0] - r_job.row[SLOT_W-1:0];
        vi     = DIST_W'((a_s < 0) ? -a_s : a_s);
        hi     = DIST_W'((b_s < 0) ? -b_s : b_s);
    end

    assign wmul = i_cfg.vweights[WGT_W*r_p1_vi +: WGT_W] * i_cfg.hweights[WGT_W*r_p1_hi +: WGT_W];

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            pmul[ch] = $signed({1'b0, r_wt}) * r_smp[ch];
            mag[ch]  = r_acc[ch][ACC_W-1] ? ACC_W'(-r_acc[ch]) : ACC_W'(r_acc[ch]);
            rnd[ch]  = {1'b0, mag[ch]} + (ACC_W + 1)'(1 << 29);
        end
    end

    assign pipe_idle = !r_issue && !r_p1_v && !r_p2_v && !r_p3_v;
    assign adjust    = i_cfg.bmode != BND_ZERO && i_cfg.bmode != BND_MIRROR;
    assign den       = adjust ? r_wsum : WSUM_W'(1 << 30);
    assign o_q_pop   = r_state == S_IDLE && !i_q_empty;
    assign load_out  = r_state == S_DONE && (!r_out_v || i_pop);

    always_ff @(posedge i_clk) begin
        r_rd    <= r_mem[{slot, cc[COL_W-1:0]}];
        r_p1_in <= tap_ok;
        r_p1_vi <= vi;
        r_p1_hi <= hi;
        r_p2_in <= r_p1_in;
        r_wt    <= wmul;
        r_p3_in <= r_p2_in;
        r_wt3   <= r_wt;
        for (int ch = 0; ch < 3; ch++) begin
            r_smp[ch]  <= $signed(r_rd[SMP_W*ch +: SMP_W]);
            r_prod[ch] <= pmul[ch][PROD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_issue <= 1'b0;
            r_p1_v  <= 1'b0;
            r_p2_v  <= 1'b0;
            r_p3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_p1_v <= r_issue;
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
            if (r_p3_v && r_p3_in) begin
                for (int ch = 0; ch < 3; ch++) begin
                    r_acc[ch] <= r_acc[ch] + ACC_W'(r_prod[ch]);
                end
                r_wsum <= r_wsum + WSUM_W'(r_wt3);
            end
            if (load_out) begin
                r_out_v <= 1'b1;
            end else if (i_pop) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_job   <= i_job;
                        r_ta    <= '0;
                        r_tb    <= '0;
                        r_issue <= 1'b1;
                        r_wsum  <= '0;
                        for (int ch = 0; ch < 3; ch++) begin
                            r_acc[ch] <= '0;
                        end
                        r_state <= S_TAPS;
                    end
                end
                S_TAPS: begin
                    if (r_issue) begin
                        if (r_tb == TAP_W'(SIDE - 1)) begin
                            r_tb <= '0;
                            if (r_ta == TAP_W'(SIDE - 1)) begin
                                r_issue <= 1'b0;
                            end else begin
                                r_ta <= r_ta + TAP_W'(1);
                            end
                        end else begin
                            r_tb <= r_tb + TAP_W'(1);
                        end
                    end else if (pipe_idle) begin
                        r_zero <= adjust && r_wsum == '0;
                        r_dsh  <= DIV_W'(den) << QBITS;
                        r_k    <= K_W'(QBITS - 1);
                        for (int ch = 0; ch < 3; ch++) begin
                            r_neg[ch] <= r_acc[ch][ACC_W-1];
                            r_rem[ch] <= DIV_W'({mag[ch], 1'b0}) + DIV_W'(den);
                            r_q[ch]   <= '0;
                            r_fin[ch] <= sat16(r_acc[ch][ACC_W-1], rnd[ch][ACC_W:30]);
                        end
                        r_state <= adjust ? S_DIV : S_DONE;
                    end
                end
                S_DIV: begin
                    for (int ch = 0; ch < 3; ch++) begin
                        if (r_rem[ch] >= r_dsh) begin
                            r_rem[ch] <= r_rem[ch] - r_dsh;
                            r_q[ch]   <= {r_q[ch][QBITS-2:0], 1'b1};
                        end else begin
                            r_q[ch]   <= {r_q[ch][QBITS-2:0], 1'b0};
                        end
                    end
                    r_dsh <= r_dsh >> 1;
                    r_k   <= r_k - K_W'(1);
                    if (r_k == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_eof <= r_job.last;
            for (int ch = 0; ch < 3; ch++) begin
                if (r_zero || (ch != 0 && !i_cfg.color)) begin
                    r_oc[ch] <= '0;
                end else if (adjust) begin
                    r_oc[ch] <= sat16(r_neg[ch], QSAT_W'(r_q[ch]));
                end else begin
                    r_oc[ch] <= r_fin[ch];
                end
            end
        end
    end

    assign o_stat.idle      = r_state == S_IDLE;
    assign o_stat.out_valid = r_out_v;
    assign o_chan0 = r_oc[0];
    assign o_chan1 = r_oc[1];
    assign o_chan2 = r_oc[2];
    assign o_eof   = r_eof;

endmodule
